// File: hdl/srr_pkg.sv
// shared constants, state encoding and divider status type for the seeded random range block
package srr_pkg;

	// linear congruential generator
	localparam logic [31:0] LCG_MUL    = 32'h41C6_4E6D;
	localparam logic [31:0] LCG_INC    = 32'd12345;
	localparam int          LCG_STEPS  = 3;

	// slice taken from each generator state and packing of the slices
	localparam int          SLICE_LSB  = 16;
	localparam int          SLICE_W    = 11;
	localparam int          PACK_SHIFT = 10;

	// packed word and divisor widths
	localparam int          WORD_W     = 31;
	localparam int          DIVISOR_W  = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_DONE
	} srr_state_t;

	// status returned by the modulo unit
	typedef struct packed {
		logic busy;
		logic done;
	} srr_div_stat_t;

endpackage

// File: hdl/seeded_random_range.sv
// top level: seeded random draw between two signed bounds
//
// A request transaction, once accepted, passes through the sequencer states in
// order: ST_LCG steps the 32-bit generator three times through one shared
// multiplier, ST_DIV_START starts the modulo unit, ST_DIV_RUN runs the
// bit-serial modulo of the packed 31-bit word by the bound difference until the
// unit reports done, and ST_DONE loads the result into the output register once
// that register is free. A new request is taken once the previous one has left
// the sequencer, while its result may still wait in the output register, so no
// request is accepted while another is in flight. A write on the configuration channel
// reloads the running seed at once; it is always ready and is meant to be used
// only while no request is in flight. When both bounds are equal the result is
// the high bound with empty_range set; the generator still advances.
module seeded_random_range
	import srr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [31:0] start_seed,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic               empty_range
);

	srr_state_t state_q, state_d;

	logic [31:0]        seed_q;
	logic [1:0]         step_q;
	logic [WORD_W-1:0]  word_q;
	logic [31:0]        base_q;
	logic [31:0]        diff_q;
	logic [31:0]        hi_q;
	logic               empty_q;
	logic               out_valid_q;
	logic [31:0]        value_q;
	logic               empty_out_q;

	logic               in_fire;
	logic               cfg_fire;
	logic               out_free;
	logic               lcg_last;
	logic               div_start;
	logic               load_out;
	logic               swap;
	logic [31:0]        base_d;
	logic [31:0]        diff_d;
	logic [31:0]        seed_next;
	logic [SLICE_W-1:0] slice;
	logic [WORD_W-1:0]  word_shift;
	logic [WORD_W-1:0]  word_next;
	srr_div_stat_t      div_stat;
	logic [31:0]        div_rem;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign in_fire   = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign lcg_last  = (step_q == 2'(LCG_STEPS - 1));

	// order the bounds and take the unsigned difference
	always_comb begin
		swap   = (low_bound >= high_bound);
		base_d = swap ? high_bound : low_bound;
		diff_d = swap ? 32'(low_bound - high_bound) : 32'(high_bound - low_bound);
	end

	// generator step and slice packing
	always_comb begin
		seed_next  = 32'(seed_q * LCG_MUL) + LCG_INC;
		slice      = seed_next[SLICE_LSB +: SLICE_W];
		word_shift = word_q << PACK_SHIFT;
		word_next  = word_shift ^ WORD_W'(slice);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_fire) state_d = ST_LCG;
			ST_LCG:       if (lcg_last) state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_RUN;
			ST_DIV_RUN:   if (div_stat.done) state_d = ST_DONE;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:      in_ready  = 1'b1;
			ST_LCG:       ;
			ST_DIV_START: div_start = 1'b1;
			ST_DIV_RUN:   ;
			ST_DONE:      load_out  = out_free;
			default:      ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				seed_q <= start_seed;
			end else if (state_q == ST_LCG) begin
				seed_q <= seed_next;
			end
			if (in_fire) begin
				step_q <= '0;
			end else if (state_q == ST_LCG) begin
				step_q <= step_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and packed word accumulation
	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q  <= base_d;
			diff_q  <= diff_d;
			hi_q    <= high_bound;
			empty_q <= (diff_d == '0);
			word_q  <= '0;
		end else if (state_q == ST_LCG) begin
			word_q <= word_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q     <= empty_q ? hi_q : 32'(base_q + div_rem);
			empty_out_q <= empty_q;
		end
	end

	srr_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (word_q),
		.divisor   (diff_q),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign empty_range = empty_out_q;

endmodule

// File: hdl/srr_mod_unit.sv
// bit-serial restoring modulo unit, one quotient bit per cycle
module srr_mod_unit
	import srr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_W-1:0]    dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output srr_div_stat_t        stat,
	output logic [DIVISOR_W-1:0] remainder
);

	localparam int CNT_W = $clog2(WORD_W);

	logic [DIVISOR_W-1:0] rem_q;
	logic [WORD_W-1:0]    dvd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W+1:0] sub;
	logic                 fits;
	logic [DIVISOR_W-1:0] rem_next;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial    = {rem_q, dvd_q[WORD_W-1]};
		sub      = {1'b0, trial} - {2'b00, divisor};
		fits     = ~sub[DIVISOR_W+1];
		rem_next = fits ? sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
	end

	// control: busy flag, bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

// File: tb/testbench.sv
// testbench for seeded_random_range: directed and random draws checked against a bit-true predictor
module testbench;
	import srr_pkg::*;

	localparam logic signed [31:0] MIN_S = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_S = 32'sh7FFF_FFFF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAW_LATENCY = 40;
	localparam int PHASE_ITEMS = 117;
	localparam int N_PHASES = 6;
	localparam int N_DIRECTED = 21;

	typedef struct packed {
		logic signed [31:0] value;
		logic empty;
	} drawn_t;

	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		bit typed;
		logic signed [31:0] want_value;
		logic want_empty;
	} bound_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic signed [31:0] start_seed;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] low_bound;
	logic signed [31:0] high_bound;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] value;
	logic empty_range;

	// predictor state and bookkeeping
	logic [31:0] gen_seed;
	drawn_t pending_draws[$];
	int fail_count;
	int cycle_count;
	int tx_idle;
	int rx_idle;

	// directed rows: typed expectations only where obvious (equal bounds, unit ranges)
	bound_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b1},
		'{MIN_S, MIN_S, 1'b1, MIN_S, 1'b1},
		'{MAX_S, MAX_S, 1'b1, MAX_S, 1'b1},
		'{-32'sd1, -32'sd1, 1'b1, -32'sd1, 1'b1},
		'{-32'sd5, -32'sd5, 1'b1, -32'sd5, 1'b1},
		'{32'sd0, 32'sd1, 1'b1, 32'sd0, 1'b0},
		'{32'sd1, 32'sd0, 1'b1, 32'sd0, 1'b0},
		'{MAX_S - 1, MAX_S, 1'b1, MAX_S - 1, 1'b0},
		'{MAX_S, MAX_S - 1, 1'b1, MAX_S - 1, 1'b0},
		'{MIN_S, MIN_S + 1, 1'b1, MIN_S, 1'b0},
		'{MIN_S, MAX_S, 1'b0, 32'sd0, 1'b0},
		'{MAX_S, MIN_S, 1'b0, 32'sd0, 1'b0},
		'{-32'sd1, 32'sd1, 1'b0, 32'sd0, 1'b0},
		'{32'sd1, -32'sd1, 1'b0, 32'sd0, 1'b0},
		'{32'sd0, MAX_S, 1'b0, 32'sd0, 1'b0},
		'{MIN_S, 32'sd0, 1'b0, 32'sd0, 1'b0},
		'{-32'sd100, 32'sd100, 1'b0, 32'sd0, 1'b0},
		'{32'sd100, -32'sd100, 1'b0, 32'sd0, 1'b0},
		'{32'sh1234_5678, 32'sh7FFF_0000, 1'b0, 32'sd0, 1'b0},
		'{32'sd0, 32'sd7, 1'b0, 32'sd0, 1'b0},
		'{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 32'sd0, 1'b0}
	};

	seeded_random_range uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.start_seed (start_seed),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.empty_range(empty_range)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one draw: step the generator three times, pack the slices, reduce into the range
	function automatic drawn_t draw_next(input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic [31:0] s1, s2, s3;
		logic [31:0] a, b, c;
		logic [31:0] word, base, diff;
		drawn_t d;
		s1 = gen_seed * LCG_MUL + LCG_INC;
		s2 = s1 * LCG_MUL + LCG_INC;
		s3 = s2 * LCG_MUL + LCG_INC;
		gen_seed = s3;
		a = 32'(s1[SLICE_LSB +: SLICE_W]);
		b = 32'(s2[SLICE_LSB +: SLICE_W]);
		c = 32'(s3[SLICE_LSB +: SLICE_W]);
		word = (((a << PACK_SHIFT) ^ b) << PACK_SHIFT) ^ c;
		word[31] = 1'b0;
		// swapped roles when the first bound is not below the second
		if (lo >= hi) begin
			base = hi;
			diff = lo - hi;
		end else begin
			base = lo;
			diff = hi - lo;
		end
		if (diff == 32'd0) begin
			d.value = hi;
			d.empty = 1'b1;
		end else begin
			d.value = base + (word % diff);
			d.empty = 1'b0;
		end
		return d;
	endfunction

	// a bound from the corners of the signed range
	function automatic logic signed [31:0] corner_bound();
		case ($urandom_range(4))
			0: return MIN_S;
			1: return MAX_S;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("mismatch on %s: expected %h, got %h", what, want, got);
		fail_count++;
	endtask

	// send one request transaction; entered and left at a falling edge
	task automatic send_request(input logic signed [31:0] lo, input logic signed [31:0] hi,
			input bit typed, input logic signed [31:0] want_value, input logic want_empty);
		int gaps;
		drawn_t d;
		gaps = 0;
		while ($urandom_range(99) < tx_idle)
			gaps++;
		if (gaps != 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		in_valid <= 1'b1;
		low_bound <= lo;
		high_bound <= hi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		d = draw_next(lo, hi);
		if (typed) begin
			d.value = want_value;
			d.empty = want_empty;
		end
		pending_draws.push_back(d);
		@(negedge clk);
	endtask

	// stop sending and wait until every outstanding draw has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// reload the seed while the block is idle
	task automatic write_seed(input logic [31:0] seed);
		cfg_valid <= 1'b1;
		start_seed <= seed;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		gen_seed = seed;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle);
	end

	// result checking
	always @(posedge clk) begin : check_results
		drawn_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_draws.size() == 0) begin
				report_mismatch("unexpected result", 32'd0, value);
			end else begin
				want = pending_draws.pop_front();
				if (value !== want.value)
					report_mismatch("value", want.value, value);
				if (empty_range !== want.empty)
					report_mismatch("empty_range", 32'(want.empty), 32'(empty_range));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		logic [31:0] seed_plan [0:N_PHASES-1];
		logic signed [31:0] lo, hi;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		start_seed = '0;
		in_valid = 1'b0;
		low_bound = '0;
		high_bound = '0;
		out_ready = 1'b0;
		gen_seed = '0;
		fail_count = 0;
		cycle_count = 0;
		tx_idle = 21;
		rx_idle = 21;
		seed_plan[0] = 32'h7FFF_FFFF;
		seed_plan[1] = 32'h8000_0000;
		seed_plan[2] = 32'hFFFF_FFFF;
		seed_plan[3] = $urandom;
		seed_plan[4] = 32'h0000_0000;
		seed_plan[5] = 32'h0000_0001;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows run from the reset seed
		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].typed,
				directed_rows[i].want_value, directed_rows[i].want_empty);

		// random phases, each under its own seed; phase two runs without stalls
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			write_seed(seed_plan[p]);
			tx_idle = (p == 2) ? 0 : 21;
			rx_idle = (p == 2) ? 0 : 21;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(9))
					0: begin
						lo = $urandom;
						hi = lo;
					end
					1, 2, 3: begin
						lo = $urandom;
						hi = lo + $urandom_range(1, 1000);
						if ($urandom_range(1))
							{lo, hi} = {hi, lo};
					end
					4: begin
						lo = corner_bound();
						hi = ($urandom_range(1) != 0) ? corner_bound() : $urandom;
					end
					default: begin
						lo = $urandom;
						hi = $urandom;
					end
				endcase
				send_request(lo, hi, 1'b0, 32'sd0, 1'b0);
			end
		end

		settle();
		repeat (DRAW_LATENCY) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/srr_pkg.sv
hdl/srr_mod_unit.sv
hdl/seeded_random_range.sv
tb/testbench.sv
